@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions with a clock and active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define RLEPBD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Implication in the same cycle, checked outside reset.
`define RLEPBD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/rlepbd_pkg.sv @@
// ---------------------------------------------------------------------------
// Run-length pattern body decoder package
// Beat types, field codes and character constants for the decoder.
// ---------------------------------------------------------------------------
package rlepbd_pkg;

  // Largest grid extent honoured; larger register values act as this.
  localparam int unsigned MAX_EXTENT = 4096;
  localparam int EXT_W = 13;
  localparam logic [EXT_W-1:0] EXT_CAP =
    (MAX_EXTENT > 8191) ? 13'h1FFF : 13'(MAX_EXTENT);
  localparam logic [EXT_W-1:0] GRID_RESET = 13'd64;

  // Input kinds.
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  // Result kinds.
  localparam logic [1:0] RES_RUN   = 2'd0;
  localparam logic [1:0] RES_DONE  = 2'd1;
  localparam logic [1:0] RES_ERROR = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_PREFIX     = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
  localparam logic [1:0] ERR_ROWS       = 2'd2;
  localparam logic [1:0] ERR_ROW_LONG   = 2'd3;

  // Register selects (byte address bit 2).
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Characters of the body.
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_LOWER_O = 8'h6F;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_P = 8'h70;
  localparam logic [7:0] CH_LOWER_Y = 8'h79;

  localparam logic [8:0] STATES_PER_PREFIX = 9'd24;
  localparam logic [8:0] TOP_STATE         = 9'd255;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] body_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [11:0] row;
    logic [11:0] column;
    logic [12:0] run_length;
    logic [7:0]  cell_state;
    logic [8:0]  state_count;
    logic [1:0]  error_code;
  } out_beat_t;

endpackage

@@ hdl/rle_pattern_body_decoder_unit.sv @@
// ---------------------------------------------------------------------------
// Run-length pattern body decoder
// Turns body characters into cell runs, a done beat or an error beat.
// ---------------------------------------------------------------------------
// One body character is taken per clock cycle while in_stall is low. Each
// character is decoded in a single pass against the parser state and any
// result is registered into a two-entry output buffer (result register plus
// skid register) that lets input keep flowing while a result waits; in_stall
// rises only when both entries hold results that have not been taken. Grid
// width and height are written through the APB-style port at byte addresses 0
// and 4; the user must do so only while idle, which the block does not enforce.
module rle_pattern_body_decoder_unit #(
  parameter int COUNT_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rlepbd_pkg::in_beat_t in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rlepbd_pkg::out_beat_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import rlepbd_pkg::*;

  localparam int SUM_W = COUNT_BITS + 1;
  localparam int MUL_W = COUNT_BITS + 4;

  // Configuration registers.
  logic [EXT_W-1:0] grid_w_r, grid_h_r;
  logic [EXT_W-1:0] w_eff, h_eff;

  // Parser state.
  logic [COUNT_BITS-1:0] pend_r, pend_nxt;
  logic [EXT_W-1:0]      col_r, col_nxt;
  logic [EXT_W-1:0]      row_r, row_nxt;
  logic [7:0]            high_r, high_nxt;
  logic                  pfx_pend_r, pfx_pend_nxt;
  logic [3:0]            pfx_val_r, pfx_val_nxt;
  logic                  fin_r, fin_nxt;

  // Output buffer.
  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_beat_t out_r, out_nxt;
  out_beat_t skid_r, skid_nxt;

  // Decode signals.
  logic                  in_acc;
  logic [7:0]            ch;
  logic                  is_digit, is_upper, is_pfx;
  logic [3:0]            dig;
  logic [MUL_W-1:0]      dig_mul;
  logic [COUNT_BITS-1:0] dig_sat;
  logic [COUNT_BITS-1:0] run;
  logic [7:0]            upper_st;
  logic [8:0]            pfx_st;
  logic [SUM_W-1:0]      col_sum, row_sum;
  logic [EXT_W-1:0]      row_adv;
  logic [8:0]            st_count;
  logic                  place_en;
  logic [7:0]            place_st;
  logic                  res_valid;
  out_beat_t             res;
  logic                  pop;

  // Configuration port: writes take effect in the access phase.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= GRID_RESET;
      grid_h_r <= GRID_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_GRID_WIDTH:  grid_w_r <= pwdata[EXT_W-1:0];
        REG_GRID_HEIGHT: grid_h_r <= pwdata[EXT_W-1:0];
        default:         grid_w_r <= grid_w_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GRID_WIDTH:  prdata = {19'd0, grid_w_r};
      REG_GRID_HEIGHT: prdata = {19'd0, grid_h_r};
      default:         prdata = '0;
    endcase
  end

  // Effective extents, capped at the largest supported grid.
  assign w_eff = (grid_w_r > EXT_CAP) ? EXT_CAP : grid_w_r;
  assign h_eff = (grid_h_r > EXT_CAP) ? EXT_CAP : grid_h_r;

  // Character classes and the arithmetic they need.
  assign in_acc   = in_valid && !in_stall;
  assign ch       = in_data.body_byte;
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_upper = (ch >= CH_UPPER_A) && (ch <= CH_UPPER_X);
  assign is_pfx   = (ch >= CH_LOWER_P) && (ch <= CH_LOWER_Y);
  assign dig      = 4'(ch - CH_ZERO);

  // Run count times ten plus the digit, saturating at the register width.
  assign dig_mul = (MUL_W'(pend_r) << 3) + (MUL_W'(pend_r) << 1) + MUL_W'(dig);
  assign dig_sat = (dig_mul[MUL_W-1:COUNT_BITS] != '0) ? {COUNT_BITS{1'b1}}
                                                       : dig_mul[COUNT_BITS-1:0];

  // A missing or zero count means a run of one.
  assign run = (pend_r == '0) ? COUNT_BITS'(1) : pend_r;

  assign upper_st = 8'(ch - CH_UPPER_A) + 8'd1;
  assign pfx_st   = ({5'd0, pfx_val_r} + 9'd1) * STATES_PER_PREFIX + {1'b0, upper_st};

  assign col_sum = SUM_W'(col_r) + SUM_W'(run);
  assign row_sum = SUM_W'(row_r) + SUM_W'(run);
  assign row_adv = (row_sum > SUM_W'(h_eff)) ? h_eff : row_sum[EXT_W-1:0];

  assign st_count = (high_r == 8'd0) ? 9'd2 : ({1'b0, high_r} + 9'd1);

  // Single-pass decode of one beat against the parser state.
  always_comb begin
    pend_nxt     = pend_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    high_nxt     = high_r;
    pfx_pend_nxt = pfx_pend_r;
    pfx_val_nxt  = pfx_val_r;
    fin_nxt      = fin_r;
    place_en     = 1'b0;
    place_st     = 8'd0;
    res_valid    = 1'b0;
    res          = '0;

    if (in_acc) begin
      if (in_data.kind == KIND_START) begin
        pend_nxt     = '0;
        col_nxt      = '0;
        row_nxt      = '0;
        high_nxt     = 8'd0;
        pfx_pend_nxt = 1'b0;
        pfx_val_nxt  = 4'd0;
        fin_nxt      = 1'b0;
      end else if (!fin_r && in_data.kind == KIND_END) begin
        fin_nxt   = 1'b1;
        res_valid = 1'b1;
        if (pfx_pend_r) begin
          res.result_kind = RES_ERROR;
          res.error_code  = ERR_PREFIX;
        end else begin
          res.result_kind = RES_DONE;
          res.state_count = st_count;
        end
      end else if (!fin_r && in_data.kind == KIND_CHAR) begin
        if (pfx_pend_r) begin
          // The letter after a prefix completes a multi-letter state.
          pfx_pend_nxt = 1'b0;
          pend_nxt     = '0;
          if (is_upper && pfx_st <= TOP_STATE) begin
            place_en = 1'b1;
            place_st = pfx_st[7:0];
          end else begin
            fin_nxt         = 1'b1;
            res_valid       = 1'b1;
            res.result_kind = RES_ERROR;
            res.error_code  = ERR_PREFIX;
          end
        end else if (is_digit) begin
          pend_nxt = dig_sat;
        end else begin
          pend_nxt = '0;
          if (ch == CH_BANG) begin
            fin_nxt         = 1'b1;
            res_valid       = 1'b1;
            res.result_kind = RES_DONE;
            res.state_count = st_count;
          end else if (ch == CH_DOLLAR) begin
            row_nxt = row_adv;
            col_nxt = '0;
          end else if (ch == CH_LOWER_B || ch == CH_DOT) begin
            place_en = 1'b1;
          end else if (ch == CH_LOWER_O) begin
            place_en = 1'b1;
            place_st = 8'd1;
          end else if (is_upper) begin
            place_en = 1'b1;
            place_st = upper_st;
          end else if (is_pfx) begin
            // The prefix keeps the run count for the letter that follows.
            pfx_pend_nxt = 1'b1;
            pfx_val_nxt  = 4'(ch - CH_LOWER_P);
            pend_nxt     = run;
          end else begin
            fin_nxt         = 1'b1;
            res_valid       = 1'b1;
            res.result_kind = RES_ERROR;
            res.error_code  = ERR_UNEXPECTED;
          end
        end
      end
    end

    // Placing a run: track the highest state, check bounds, then advance the column.
    if (place_en) begin
      if (place_st > high_r) begin
        high_nxt = place_st;
      end
      if (row_r >= h_eff) begin
        fin_nxt         = 1'b1;
        res_valid       = 1'b1;
        res.result_kind = RES_ERROR;
        res.error_code  = ERR_ROWS;
      end else if (col_sum > SUM_W'(w_eff)) begin
        fin_nxt         = 1'b1;
        res_valid       = 1'b1;
        res.result_kind = RES_ERROR;
        res.error_code  = ERR_ROW_LONG;
      end else begin
        col_nxt = col_sum[EXT_W-1:0];
        if (place_st != 8'd0) begin
          res_valid       = 1'b1;
          res.result_kind = RES_RUN;
          res.row         = row_r[11:0];
          res.column      = col_r[11:0];
          res.run_length  = run[12:0];
          res.cell_state  = place_st;
        end
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= '0;
      col_r      <= '0;
      row_r      <= '0;
      high_r     <= 8'd0;
      pfx_pend_r <= 1'b0;
      pfx_val_r  <= 4'd0;
      fin_r      <= 1'b0;
    end else begin
      pend_r     <= pend_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      high_r     <= high_nxt;
      pfx_pend_r <= pfx_pend_nxt;
      pfx_val_r  <= pfx_val_nxt;
      fin_r      <= fin_nxt;
    end
  end

  // Two-entry output buffer: the head drives the port, the skid catches a
  // result that arrives while the head is held.
  assign pop = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = res_valid;
        skid_nxt       = res;
      end else begin
        out_valid_nxt  = res_valid;
        out_nxt        = res;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ hdl/rlepbd_checker.sv @@
// ---------------------------------------------------------------------------
// Run-length pattern body decoder checker
// Port-level assertions on result beats, bound to the decoder top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rlepbd_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input rlepbd_pkg::out_beat_t out_data
);
  import rlepbd_pkg::*;

  // A stalled result beat stays offered and unchanged.
  `RLEPBD_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data))

  // Only the three defined result kinds are ever sent.
  `RLEPBD_ASSERT_IMPLY(a_kind_legal, clk, rst_n, out_valid, out_data.result_kind == RES_RUN || out_data.result_kind == RES_DONE || out_data.result_kind == RES_ERROR)

  // A run beat carries a nonzero length and state and no done or error data.
  `RLEPBD_ASSERT_IMPLY(a_run_fields, clk, rst_n, out_valid && out_data.result_kind == RES_RUN, out_data.run_length != 13'd0 && out_data.cell_state != 8'd0 && out_data.state_count == 9'd0 && out_data.error_code == ERR_PREFIX)

  // A done beat reports at least two states and no run data.
  `RLEPBD_ASSERT_IMPLY(a_done_fields, clk, rst_n, out_valid && out_data.result_kind == RES_DONE, out_data.state_count >= 9'd2 && out_data.run_length == 13'd0 && out_data.cell_state == 8'd0)

endmodule

bind rle_pattern_body_decoder_unit rlepbd_checker u_rlepbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
